// ===== hdl/sha512_pkg.sv =====
// shared constants and types for the sha-512 hash engine
`timescale 1ns / 1ps
package sha512_pkg;

  localparam int QueueDepth = 4;
  localparam logic [60:0] TotalMax = {61{1'b1}};

  // one queued word for the compression back end
  typedef struct packed {
    logic [63:0] word;
    logic        final_word;
    logic        too_long;
  } queue_item_t;

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ===== hdl/sha512_hash_engine.sv =====
// top level of the sha-512 hash engine
`timescale 1ns / 1ps
// sha-512 over a stream of 64-bit big-endian words. s_tdata carries the word,
// the valid byte count of a final word and s_tlast marks it. the front end
// counts bytes (saturating at 2^61-1), pads and appends the bit length; a
// four-entry queue feeds the compression core, which loads 16 words at one
// transfer a cycle while the queue holds words, then runs 80 rounds at one
// round per cycle and then adds the result into the hash; it takes no new word
// until that block is through. after the last block the eight digest words
// leave on m_*, index 0 first, tlast on index 7; the engine then starts over
// with the initial hash for the next message.
module sha512_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // message_word[63:0], byte_count[67:64], zero pad
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // digest_word[63:0], word_index[66:64], zero pad
  output logic        m_tlast,   // last_of_digest
  output logic        m_tuser    // too_long
);
  import sha512_pkg::*;

  queue_item_t f_item, c_item;
  logic f_valid, f_ready, c_valid, c_ready;
  logic [63:0] dw;
  logic [2:0]  di;

  sha512_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_word(s_tdata[63:0]), .in_count(s_tdata[67:64]), .in_last(s_tlast),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  // queue decouples padding from the round loop
  sha512_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(c_valid), .rd_ready(c_ready), .rd_item(c_item)
  );

  sha512_core u_core (
    .clk(clk), .rst(rst), .q_valid(c_valid), .q_ready(c_ready), .q_item(c_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_word(dw), .out_index(di),
    .out_last(m_tlast), .out_too_long(m_tuser)
  );

  assign m_tdata = {5'd0, di, dw};
endmodule

// ===== hdl/sha512_front.sv =====
// front end: byte counting, padding and length word generation
`timescale 1ns / 1ps
module sha512_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [63:0]            in_word,
  input  logic [3:0]             in_count,
  input  logic                   in_last,
  output logic                   q_valid,
  input  logic                   q_ready,
  output sha512_pkg::queue_item_t q_item
);
  import sha512_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StLen  = 2'd2;

  logic [1:0]  state;
  logic [3:0]  pos;
  logic [60:0] total;
  logic        sat;
  logic        pad_full;   // 0x80 word still owed after a full last word
  logic [3:0]  n;
  logic [60:0] total_add;
  logic        will_sat;
  logic [63:0] mask;
  logic [63:0] last_data;

  always_comb begin
    n = in_last ? ((in_count == 4'd0) ? 4'd1 : (in_count > 4'd8) ? 4'd8 : in_count) : 4'd8;
    will_sat = total > (TotalMax - {57'd0, n});
    total_add = will_sat ? TotalMax : total + {57'd0, n};
    mask = ~64'd0 << (7'd64 - {n, 3'b000});
    last_data = (n == 4'd8) ? in_word
              : ((in_word & mask) | (64'h80 << (7'd56 - {n, 3'b000})));
  end

  assign in_ready = (state == StIdle) && q_ready;

  always_comb begin
    q_valid = 1'b0;
    q_item = '{word: 64'd0, final_word: 1'b0, too_long: sat};
    unique case (state)
      StIdle: begin
        q_valid = in_valid;
        q_item.word = in_last ? last_data : in_word;
      end
      StPad: begin
        q_valid = 1'b1;
        q_item.word = pad_full ? 64'h8000000000000000 : 64'd0;
      end
      StLen: begin
        q_valid = 1'b1;
        q_item.word = {total, 3'b000};
        q_item.final_word = 1'b1;
      end
      default: q_valid = 1'b0;
    endcase
  end

  // the upper length word is always a zero pushed from the pad state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      pos <= 4'd0;
      total <= 61'd0;
      sat <= 1'b0;
      pad_full <= 1'b0;
    end else if (q_valid && q_ready) begin
      pos <= pos + 4'd1;
      unique case (state)
        StIdle: begin
          total <= total_add;
          sat <= sat | will_sat;
          if (in_last) begin
            pad_full <= (n == 4'd8);
            state <= StPad;
          end
        end
        StPad: begin
          pad_full <= 1'b0;
          if (pos == 4'd14 && !pad_full) state <= StLen;
        end
        StLen: begin
          state <= StIdle;
          total <= 61'd0;
          sat <= 1'b0;
        end
        default: state <= StIdle;
      endcase
    end
  end

  // the length word always lands in the last slot of a block
  a_len_slot: assert property (@(posedge clk) disable iff (rst)
    (state == StLen) |-> (pos == 4'd15)) else $error("length word misplaced");
  a_pad_full: assert property (@(posedge clk) disable iff (rst)
    (state == StLen) |-> !pad_full) else $error("pad byte lost");
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !in_ready) else $error("input taken while padding");
endmodule

// ===== hdl/sha512_queue.sv =====
// small fifo between front end and compression core
`timescale 1ns / 1ps
module sha512_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_valid,
  output logic                   wr_ready,
  input  sha512_pkg::queue_item_t wr_item,
  output logic                   rd_valid,
  input  logic                   rd_ready,
  output sha512_pkg::queue_item_t rd_item
);
  import sha512_pkg::*;

  localparam int AW = $clog2(QueueDepth);
  queue_item_t slots [QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   fill;
  logic wr, rd;

  assign wr_ready = fill != (AW+1)'(QueueDepth);
  assign rd_valid = fill != '0;
  assign rd_item = slots[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      fill <= fill + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ===== hdl/sha512_core.sv =====
// back end: block buffer, 80 round compression and digest output
`timescale 1ns / 1ps
module sha512_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  sha512_pkg::queue_item_t q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            out_word,
  output logic [2:0]             out_index,
  output logic                   out_last,
  output logic                   out_too_long
);
  import sha512_pkg::*;

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [1:0]  state;
  logic [3:0]  pos;
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  logic        fin;
  logic        tl;
  logic [63:0] w [16];
  logic [63:0] hv [8];
  logic [63:0] v [8];
  logic [63:0] wt, s0, s1, t1, t2, x2, x15;

  assign q_ready = (state == StLoad);
  assign out_valid = (state == StOut);
  assign out_word = hv[oidx];
  assign out_index = oidx;
  assign out_last = (oidx == 3'd7);
  assign out_too_long = tl;

  // schedule word: the window w holds the last 16, w[0] is oldest
  always_comb begin
    x2 = w[14];
    x15 = w[1];
    s1 = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
    s0 = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
    wt = (rnd < 7'd16) ? w[rnd[3:0]] : (s1 + w[9] + s0 + w[0]);
    t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + wt;
    t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (state == StLoad && q_valid) w[pos] <= q_item.word;
    if (state == StRound) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      if (rnd >= 7'd16) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wt;
      end
    end
    if (state == StLoad && q_valid && pos == 4'd15) begin
      for (int i = 0; i < 8; i++) v[i] <= hv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StLoad;
      pos <= 4'd0;
      rnd <= 7'd0;
      oidx <= 3'd0;
      fin <= 1'b0;
      tl <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= InitHash[i];
    end else begin
      unique case (state)
        StLoad: if (q_valid) begin
          pos <= pos + 4'd1;
          if (pos == 4'd15) begin
            state <= StRound;
            rnd <= 7'd0;
            fin <= q_item.final_word;
            tl <= q_item.too_long;
          end
        end
        StRound: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + v[i];
          state <= fin ? StOut : StLoad;
          oidx <= 3'd0;
        end
        StOut: if (out_ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            state <= StLoad;
            for (int i = 0; i < 8; i++) hv[i] <= InitHash[i];
          end
        end
        default: state <= StLoad;
      endcase
    end
  end

  a_rnd: assert property (@(posedge clk) disable iff (rst)
    (state == StRound) |-> (rnd < 7'd80)) else $error("round overrun");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    (state == StOut) |-> (pos == 4'd0)) else $error("digest mid block");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == StOut) |-> fin) else $error("digest without final block");
endmodule

// ===== tb/sha512_digest_checker.sv =====
// checker that predicts and compares the sha-512 digest stream
`timescale 1ns / 1ps
module sha512_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          errors,
  output int          pending
);
  import sha512_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
    logic        too_long;
  } digest_word_t;

  digest_word_t digest_words_due[$];

  logic [63:0] chain [8];
  logic [63:0] block [16];
  logic [3:0]  fill;
  logic [60:0] msg_bytes;
  logic        saturated;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return 64'({x, x} >> n);
  endfunction

  task automatic reset_hash();
    for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
    fill = '0;
    msg_bytes = '0;
    saturated = 1'b0;
  endtask

  task automatic compress_block();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] wt, t1, t2, x2, x15;
    for (int i = 0; i < 16; i++) w[i] = block[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x2 = w[(t - 2) % 16];
        x15 = w[(t - 15) % 16];
        wt = (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6)) + w[(t - 7) % 16]
           + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7)) + w[t % 16];
        w[t % 16] = wt;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + wt;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic push_word(input logic [63:0] w);
    block[fill] = w;
    fill = fill + 4'd1;
    if (fill == 4'd0) compress_block();
  endtask

  // saturating byte counter
  task automatic add_bytes(input int n);
    if (msg_bytes > TotalMax - 61'(n)) begin
      msg_bytes = TotalMax;
      saturated = 1'b1;
    end else begin
      msg_bytes = msg_bytes + 61'(n);
    end
  endtask

  task automatic accept_word(input logic [63:0] word, input logic [3:0] count,
                             input logic last);
    int n;
    logic [63:0] mask;
    digest_word_t d;
    if (!last) begin
      add_bytes(8);
      push_word(word);
    end else begin
      n = (count == 0) ? 1 : (count > 8) ? 8 : count;
      add_bytes(n);
      if (n < 8) begin
        mask = ~64'd0 << (64 - 8 * n);
        push_word((word & mask) | (64'h80 << (56 - 8 * n)));
      end else begin
        push_word(word);
        push_word(64'h8000000000000000);
      end
      while (fill != 4'd14) push_word('0);
      push_word('0);
      push_word({msg_bytes, 3'b000});
      for (int k = 0; k < 8; k++) begin
        d.word = chain[k];
        d.index = 3'(k);
        d.last = (k == 7);
        d.too_long = saturated;
        digest_words_due.push_back(d);
      end
      reset_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    reset_hash();
  end

  always @(posedge clk) begin
    digest_word_t d;
    if (!rst) begin
      if (s_tvalid && s_tready) accept_word(s_tdata[63:0], s_tdata[67:64], s_tlast);
      if (m_tvalid && m_tready) begin
        if (digest_words_due.size() == 0) begin
          report_mismatch("unexpected digest transfer", m_tdata[63:0], '0);
        end else begin
          d = digest_words_due.pop_front();
          if (m_tdata[63:0] !== d.word) report_mismatch("digest_word", m_tdata[63:0], d.word);
          if (m_tdata[66:64] !== d.index) report_mismatch("word_index", m_tdata[66:64], d.index);
          if (m_tdata[71:67] !== '0) report_mismatch("tdata pad", m_tdata[71:67], '0);
          if (m_tlast !== d.last) report_mismatch("last_of_digest", m_tlast, d.last);
          if (m_tuser !== d.too_long) report_mismatch("too_long", m_tuser, d.too_long);
        end
      end
    end
    pending = digest_words_due.size();
  end

endmodule

// ===== tb/sha512_hash_engine_test.sv =====
// stimulus and verdict for the sha-512 hash engine
`timescale 1ns / 1ps
module sha512_hash_engine_test;

  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  int errors;
  int pending;
  int cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int words_sent = 0;

  always #2 clk = ~clk;

  sha512_hash_engine dut (.*);

  sha512_digest_checker checker_inst (.*);

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) m_tready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one word transfer on the slave side, with random gaps ahead of it
  task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                           input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, count, word};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // message of n words; byte count on non-final words is junk the engine ignores
  task automatic send_message(input int n, input logic [3:0] final_count);
    for (int i = 0; i < n - 1; i++) send_word(random_word(), 4'($urandom_range(15)), 1'b0);
    send_word(random_word(), final_count, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and the clamped byte counts
    sender_idle_pct = 21;
    receiver_stall_pct = 80;
    send_word('0, 4'd0, 1'b1);           // zero count taken as one byte
    send_word('1, 4'd8, 1'b1);           // full final word, padding spills
    send_word('1, 4'd15, 1'b1);          // oversized count taken as eight
    send_word(64'h0123456789abcdef, 4'd1, 1'b1);
    send_word(64'hfedcba9876543210, 4'd7, 1'b1);
    send_message(14, 4'd8);              // length field crosses into a second block

    // random messages in three idling phases
    while (words_sent < 200) begin
      if (words_sent >= 90) begin
        sender_idle_pct = 80;
        receiver_stall_pct = 21;
      end
      if (words_sent >= 150) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      send_message(($urandom_range(3) == 0) ? $urandom_range(13, 34) : $urandom_range(1, 12),
                   4'($urandom_range(15)));
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    // let the checker take in the last transfer before looking at its queue
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
